/* hdl/sukl_pkg.sv */
`timescale 1ns / 1ps

package sukl_pkg;

  localparam int DEPTH      = 16;
  localparam int KEY_BYTES  = 8;
  localparam int KEY_W      = 64;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAP_W      = 5;
  localparam int KIND_W     = 2;
  localparam int OUT_DATA_W = ((1 + KEY_W + 7) / 8) * 8;

  // Only the leading KEY_BYTES bytes of a key take part; the rest read as zero.
  localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BYTES >= 8) ? {KEY_W{1'b1}} :
                                          ~({KEY_W{1'b1}} >> (8 * KEY_BYTES));

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [KIND_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_DUMP   = 2'd3
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load_item;
    logic             do_insert;
    logic             do_remove;
    logic             load_out;
    logic             out_found;
    logic             out_last;
    logic             out_use_entry;
    logic [IDX_W-1:0] dump_idx;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t              kind;
    logic             hit;
    logic [CNT_W-1:0] count;
  } sts_t;

endpackage

/* hdl/sorted_unique_key_list_core.sv */
`timescale 1ns / 1ps

// Sorted list of up to sixteen distinct 64-bit keys, kept in ascending
// unsigned order in a chain of register cells. Each input transfer carries an
// operation in s_axis_tuser (0 insert, 1 remove, 2 search, 3 dump) and a key
// in s_axis_tdata. Insert and remove produce no output transfer; an insert is
// dropped when the list is full or already holds the key, and a remove of an
// absent key is dropped. A search produces one transfer with the found flag
// and a zero key. A dump produces one transfer per stored key in ascending
// order with the found flag set and tlast on the final one; an empty list
// produces nothing. The block works on one item at a time: insert, remove and
// search pass through a single execute state before ready returns, as every
// cell compares and shifts at once; a dump then moves to a dump state and sends
// one stored key at a time through the single output register.
// Downstream stalls lengthen search and dump. The capacity register (reset 16)
// may be written only while the block is idle.

module sorted_unique_key_list_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [sukl_pkg::KEY_W-1:0]         s_axis_tdata,  // [63:0] key
  input  logic [sukl_pkg::KIND_W-1:0]        s_axis_tuser,  // [1:0] kind
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] found, [64:1] entry_key, upper bits zero
  output logic [sukl_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast,  // last_entry
  input  logic                               cfg_wr_en,
  input  logic [sukl_pkg::CAP_W-1:0]         cfg_wr_data   // capacity
);
  import sukl_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic             out_found;
  logic [KEY_W-1:0] out_key;

  sukl_controller u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .sts           (sts),
    .cmd           (cmd)
  );

  sukl_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_key    (s_axis_tdata),
    .in_kind   (s_axis_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_found (out_found),
    .out_key   (out_key),
    .out_last  (m_axis_tlast)
  );

  // Output word: found flag in the low bit, key above it, zero padding on top.
  assign m_axis_tdata = {{(OUT_DATA_W - KEY_W - 1){1'b0}}, out_key, out_found};

  // The entry count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sts.count <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  // An executed insert grows the list by exactly one entry.
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    cmd.do_insert |=> sts.count == $past(sts.count) + CNT_W'(1))
    else $error("insert did not grow the list by one");

  // An executed remove shrinks the list by exactly one entry.
  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    cmd.do_remove |=> sts.count == $past(sts.count) - CNT_W'(1))
    else $error("remove did not shrink the list by one");

  // A new result is never loaded over one that is still stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("output register overwritten while stalled");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second item accepted while one is in work");

endmodule

/* hdl/sukl_datapath.sv */
`timescale 1ns / 1ps

module sukl_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [sukl_pkg::KEY_W-1:0]    in_key,
  input  logic [sukl_pkg::KIND_W-1:0]   in_kind,
  input  sukl_pkg::cmd_t                cmd,
  output sukl_pkg::sts_t                sts,
  output logic                          out_found,
  output logic [sukl_pkg::KEY_W-1:0]    out_key,
  output logic                          out_last
);
  import sukl_pkg::*;

  logic [KEY_W-1:0] entries [DEPTH];
  logic [KEY_W-1:0] lower   [DEPTH];
  logic [KEY_W-1:0] upper   [DEPTH];
  logic [CNT_W-1:0] count;
  logic [KEY_W-1:0] key_r;
  op_t              kind_r;
  logic [DEPTH-1:0] gt;
  logic [DEPTH-1:0] ge;
  logic [DEPTH-1:0] eq;
  logic [DEPTH-1:0] gt_prev;

  // Every cell compares its own entry against the held key. Since the list is
  // sorted, the greater-than flags form a thermometer over the valid cells.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i] = (CNT_W'(i) < count) && (entries[i] > key_r);
      ge[i] = (CNT_W'(i) < count) && (entries[i] >= key_r);
      eq[i] = (CNT_W'(i) < count) && (entries[i] == key_r);
    end
    gt_prev = DEPTH'({gt, 1'b0});
    lower[0] = '0;
    for (int i = 1; i < DEPTH; i++) begin
      lower[i] = entries[i-1];
    end
    for (int i = 0; i < DEPTH - 1; i++) begin
      upper[i] = entries[i+1];
    end
    upper[DEPTH-1] = entries[DEPTH-1];
  end

  assign sts.kind  = kind_r;
  assign sts.hit   = |eq;
  assign sts.count = count;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      key_r  <= in_key & KEY_MASK;
      kind_r <= op_t'(in_kind);
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd.do_insert) begin
        if (gt_prev[i]) begin
          entries[i] <= lower[i];
        end else if (gt[i] || (CNT_W'(i) == count)) begin
          entries[i] <= key_r;
        end
      end else if (cmd.do_remove) begin
        if (ge[i]) begin
          entries[i] <= upper[i];
        end
      end
    end
    if (cmd.load_out) begin
      out_found <= cmd.out_found;
      out_last  <= cmd.out_last;
      out_key   <= cmd.out_use_entry ? entries[cmd.dump_idx] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.do_insert) begin
      count <= count + CNT_W'(1);
    end else if (cmd.do_remove) begin
      count <= count - CNT_W'(1);
    end
  end

endmodule

/* hdl/sukl_controller.sv */
`timescale 1ns / 1ps

module sukl_controller (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic                        cfg_wr_en,
  input  logic [sukl_pkg::CAP_W-1:0]  cfg_wr_data,
  input  sukl_pkg::sts_t              sts,
  output sukl_pkg::cmd_t              cmd
);
  import sukl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CAP_W-1:0] capacity;
  logic [CNT_W-1:0] limit;
  logic [IDX_W-1:0] idx;
  logic             out_free;
  logic             dump_last;

  assign s_axis_tready = (state == S_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign dump_last     = (CNT_W'(idx) + CNT_W'(1)) == sts.count;

  // Effective capacity is the register clipped to the number of cells.
  always_comb begin
    if (CNT_W'(capacity) < CNT_W'(DEPTH)) begin
      limit = CNT_W'(capacity);
    end else begin
      limit = CNT_W'(DEPTH);
    end
  end

  always_comb begin
    state_next        = state;
    cmd               = '0;
    cmd.dump_idx      = idx;
    cmd.load_item     = s_axis_tvalid && s_axis_tready;
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.kind)
          OP_INSERT: begin
            cmd.do_insert = (sts.count < limit) && !sts.hit;
            state_next    = S_IDLE;
          end
          OP_REMOVE: begin
            cmd.do_remove = sts.hit;
            state_next    = S_IDLE;
          end
          OP_SEARCH: begin
            if (out_free) begin
              cmd.load_out  = 1'b1;
              cmd.out_found = sts.hit;
              cmd.out_last  = 1'b1;
              state_next    = S_IDLE;
            end
          end
          OP_DUMP: begin
            if (sts.count == '0) begin
              state_next = S_IDLE;
            end else begin
              state_next = S_DUMP;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_DUMP: begin
        if (out_free) begin
          cmd.load_out      = 1'b1;
          cmd.out_found     = 1'b1;
          cmd.out_last      = dump_last;
          cmd.out_use_entry = 1'b1;
          if (dump_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      capacity      <= CAP_RESET;
      idx           <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (cmd.load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (state == S_EXEC) begin
        idx <= '0;
      end else if (state == S_DUMP && cmd.load_out) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

endmodule

/* verif/sorted_key_list_checker.sv */
`timescale 1ns / 1ps

// Watches both streams and the capacity port, keeps its own copy of the sorted
// list, and compares every output transfer with the oldest predicted one.
module sorted_key_list_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [sukl_pkg::KEY_W-1:0]      s_axis_tdata,  // [63:0] key
  input  logic [sukl_pkg::KIND_W-1:0]     s_axis_tuser,  // [1:0] kind
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] found, [64:1] entry_key, upper bits zero
  input  logic [sukl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            m_axis_tlast,  // last_entry
  input  logic                            cfg_wr_en,
  input  logic [sukl_pkg::CAP_W-1:0]      cfg_wr_data,   // capacity
  output int                              mismatch_count,
  output int                              pending_results,
  output int                              results_checked
);
  import sukl_pkg::*;

  typedef struct packed {
    logic             found;
    logic [KEY_W-1:0] entry_key;
    logic             last_entry;
  } list_result_t;

  logic [KEY_W-1:0] stored_keys[$];
  list_result_t     expected_results[$];
  logic [CAP_W-1:0] capacity = CAP_RESET;
  int               mismatches = 0;
  int               checked = 0;

  // Updates the list copy for one accepted command and queues its outputs.
  task automatic apply_list_op(input op_t kind, input logic [KEY_W-1:0] raw_key);
    logic [KEY_W-1:0] k;
    int               pos;
    int               room;
    list_result_t     r;
    k = raw_key & KEY_MASK;
    pos = -1;
    foreach (stored_keys[i]) if (stored_keys[i] == k) pos = i;
    // A capacity above the store depth is clipped to the depth.
    room = (int'(capacity) < DEPTH) ? int'(capacity) : DEPTH;
    case (kind)
      OP_INSERT: begin
        if (stored_keys.size() < room && pos < 0) begin
          pos = 0;
          while (pos < stored_keys.size() && stored_keys[pos] < k) pos++;
          stored_keys.insert(pos, k);
        end
      end
      OP_REMOVE: begin
        if (pos >= 0) stored_keys.delete(pos);
      end
      OP_SEARCH: begin
        r.found = (pos >= 0);
        r.entry_key = '0;
        r.last_entry = 1'b1;
        expected_results.push_back(r);
      end
      default: begin
        foreach (stored_keys[i]) begin
          r.found = 1'b1;
          r.entry_key = stored_keys[i];
          r.last_entry = (i == stored_keys.size() - 1);
          expected_results.push_back(r);
        end
      end
    endcase
  endtask

  task automatic note_mismatch(input string what, input list_result_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected found=%0b key=%h last=%0b, got found=%0b key=%h last=%0b pad=%h",
               $time, what, want.found, want.entry_key, want.last_entry, m_axis_tdata[0],
               m_axis_tdata[KEY_W:1], m_axis_tlast, m_axis_tdata[OUT_DATA_W-1:KEY_W+1]);
  endtask

  always @(posedge clk) begin : watch
    list_result_t want;
    if (rst) begin
      stored_keys.delete();
      expected_results.delete();
      capacity = CAP_RESET;
    end else begin
      if (cfg_wr_en) capacity = cfg_wr_data;
      if (m_axis_tvalid && m_axis_tready) begin
        checked++;
        if (expected_results.size() == 0) begin
          note_mismatch("output transfer with nothing pending", '0);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata[0] !== want.found || m_axis_tdata[KEY_W:1] !== want.entry_key ||
              m_axis_tdata[OUT_DATA_W-1:KEY_W+1] !== '0 || m_axis_tlast !== want.last_entry)
            note_mismatch("output transfer differs", want);
        end
      end
      if (s_axis_tvalid && s_axis_tready) apply_list_op(op_t'(s_axis_tuser), s_axis_tdata);
    end
    mismatch_count <= mismatches;
    pending_results <= expected_results.size();
    results_checked <= checked;
  end

endmodule

/* verif/sorted_unique_key_list_core_tb.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for the sorted key list. A checker module beside the
// block predicts and compares; this module only drives commands, capacity
// writes and downstream back-pressure, then reports the outcome.
module sorted_unique_key_list_core_tb;
  import sukl_pkg::*;

  // A long downstream hold-off stays well inside the quiet-cycle limit.
  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 10;
  localparam int POOL_SIZE     = 24;

  // Two readable keys: "ABC" and "ZED", zero padded.
  localparam logic [KEY_W-1:0] KEY_ABC = 64'h4142_4300_0000_0000;
  localparam logic [KEY_W-1:0] KEY_ZED = 64'h5A45_4400_0000_0000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [KEY_W-1:0]      s_axis_tdata = '0;   // [63:0] key
  logic [KIND_W-1:0]     s_axis_tuser = '0;   // [1:0] kind
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // [0] found, [64:1] entry_key
  logic                  m_axis_tlast;        // last_entry
  logic                  cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]      cfg_wr_data = '0;    // capacity

  int mismatch_count;
  int pending_results;
  int results_checked;

  // Idle and stall percentages for the current phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Hold-off handshake: the stimulus flips hold_req, the receiver process
  // notices the difference and counts the hold-off down on its own.
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int   hold_left = 0;

  int               items_sent = 0;
  int               quiet_cycles = 0;
  logic [KEY_W-1:0] key_pool[POOL_SIZE];

  sorted_unique_key_list_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  sorted_key_list_checker list_check (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tlast    (m_axis_tlast),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .results_checked (results_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Downstream side: a pending hold-off wins; otherwise tready drops at the
  // phase's stall rate.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: any transfer or capacity write counts as progress.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one command and returns in the cycle it is accepted. Valid stays
  // high on return, so back-to-back commands never lower and raise it in the
  // same step; a random gap lowers it first.
  task automatic send_item(input op_t kind, input logic [KEY_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= key;
    s_axis_tuser <= kind;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  // Waits until every predicted output transfer has come out, then leaves
  // time for an insert or remove that is still being worked on.
  task automatic drain_list_results;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Most keys come from a small pool so that duplicates, removes and searches
  // hit stored entries; the rest are fully random.
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(99) < 75) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return {$urandom, $urandom};
  endfunction

  // One phase of random commands at a given capacity and idling mode. The
  // remaining share after inserts splits into removes, searches and dumps.
  task automatic run_phase(input logic [CAP_W-1:0] cap, input int idle_pct,
                           input int stall_pct, input int insert_pct, input int count,
                           input bit with_hold);
    int  r;
    op_t kind;
    drain_list_results();
    write_capacity(cap);
    send_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
    if (with_hold) hold_req <= ~hold_req;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < insert_pct)
        kind = OP_INSERT;
      else if (r < insert_pct + (100 - insert_pct) * 2 / 5)
        kind = OP_REMOVE;
      else if (r < insert_pct + (100 - insert_pct) * 3 / 4)
        kind = OP_SEARCH;
      else
        kind = OP_DUMP;
      send_item(kind, pick_key());
    end
  endtask

  initial begin
    // Pool: both extremes, the top bit alone, neighbors differing in the
    // lowest bit, and random keys.
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = {1'b1, {(KEY_W - 1){1'b0}}};
    key_pool[3] = KEY_ABC;
    key_pool[4] = KEY_ABC + 1;
    for (int i = 5; i < POOL_SIZE; i++)
      key_pool[i] = (i % 4 == 0) ? key_pool[i - 1] + 1 : {$urandom, $urandom};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset capacity of sixteen.
    send_item(OP_DUMP, '0);            // empty list gives no output
    send_item(OP_REMOVE, KEY_ABC);     // remove from an empty list
    send_item(OP_SEARCH, '0);
    send_item(OP_INSERT, '1);
    send_item(OP_INSERT, '0);
    send_item(OP_INSERT, KEY_ABC);
    send_item(OP_INSERT, KEY_ABC);     // duplicate is dropped
    send_item(OP_SEARCH, '1);
    send_item(OP_SEARCH, KEY_ABC + 1); // absent neighbor
    send_item(OP_DUMP, '1);
    send_item(OP_REMOVE, KEY_ABC - 1); // absent key
    send_item(OP_REMOVE, '0);
    send_item(OP_DUMP, '0);

    // Capacity lowered below the current count: entries stay, inserts are
    // dropped until removes make room.
    drain_list_results();
    write_capacity(CAP_W'(1));
    send_item(OP_INSERT, KEY_ZED);
    send_item(OP_DUMP, '0);
    send_item(OP_REMOVE, '1);
    send_item(OP_REMOVE, KEY_ABC);
    send_item(OP_INSERT, KEY_ZED);
    send_item(OP_INSERT, KEY_ABC);     // full at one entry
    send_item(OP_DUMP, '0);

    // Capacity zero ignores every insert.
    drain_list_results();
    write_capacity(CAP_W'(0));
    send_item(OP_INSERT, KEY_ABC);
    send_item(OP_SEARCH, KEY_ZED);
    send_item(OP_DUMP, '0);

    // Random phases across capacities and idling modes. Capacity 31 is
    // above the store depth, so the list tops out at sixteen entries.
    run_phase(CAP_W'(16), 0, 0, 40, 60, 1'b0);
    run_phase(CAP_W'(31), 46, 0, 60, 60, 1'b0);
    run_phase(CAP_W'(5), 0, 46, 40, 50, 1'b0);
    run_phase(CAP_W'($urandom_range(2, 15)), 16, 16, 45, 50, 1'b0);
    run_phase(CAP_W'(1), 0, 0, 40, 30, 1'b0);
    run_phase(CAP_W'(0), 16, 16, 30, 20, 1'b0);
    // Last phase: downstream holds off while commands keep coming, so the
    // block backs up and stops taking input.
    run_phase(CAP_W'(16), 0, 0, 50, 60, 1'b1);

    drain_list_results();
    repeat (20) @(posedge clk);

    $display("Sent %0d commands and checked %0d output transfers", items_sent,
             results_checked);
    $display("Capacities 16, 1, 0, 31, 5 and random, four idling modes, one long hold-off");
    if (mismatch_count == 0 && pending_results == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
